// File: hdl/vtpd_pkg.sv
package vtpd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DW            = 32;  // coordinate and entry width
  localparam int unsigned SW            = 66;  // signed column sum width
  localparam int unsigned MW            = SW - 1;  // column sum magnitude width
  localparam int unsigned QB            = 33;  // quotient bits resolved by the divider
  localparam int unsigned DIM           = 4;
  localparam int unsigned NENT          = DIM * DIM;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_XFORM = 1'b1
  } req_e;

  // Side information that travels beside the divider.
  typedef struct packed {
    logic               valid;
    logic               wz;
    logic [2:0]         dneg;
    logic               usat;
    logic [2:0][DW-1:0] uval;
  } side_t;

  localparam logic [SW-1:0] POS_LIM = SW'(64'h0000_0000_7FFF_FFFF);
  localparam logic [SW-1:0] NEG_LIM = SW'(64'h0000_0000_8000_0000);

  // Clamp a sign and magnitude to 32 bits. Returns {clamped, value}.
  function automatic logic [DW:0] sat32(input logic neg, input logic [SW-1:0] m,
                                        input logic big);
    logic [DW:0]   r;
    logic [DW-1:0] lo;
    lo = m[DW-1:0];
    if (neg) begin
      if (big || (m > NEG_LIM)) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, (~lo) + 32'd1};
    end else begin
      if (big || (m > POS_LIM)) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, lo};
    end
    return r;
  endfunction

endpackage

// File: hdl/vtpd_divider.sv
module vtpd_divider #(
  parameter int unsigned FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [vtpd_pkg::MW-1:0] num_i,
  input  logic [vtpd_pkg::MW-1:0] den_i,
  output logic [vtpd_pkg::QB-1:0] quo_o,
  output logic [vtpd_pkg::MW:0]   rem_o,
  output logic [vtpd_pkg::MW-1:0] den_o,
  output logic                    ovf_o
);

  localparam int unsigned MW = vtpd_pkg::MW;
  localparam int unsigned QB = vtpd_pkg::QB;
  localparam int unsigned RW = MW + 1;
  localparam int unsigned CW = MW + QB + FRAC_BITS;

  logic [RW-1:0] rem_q [QB+1];
  logic [QB-1:0] lo_q  [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [MW-1:0] den_q [QB+1];
  logic          ovf_q [QB+1];

  logic [CW-1:0] nsh, dsh;
  logic [RW-1:0] rem_d [QB];
  logic          ge    [QB];

  // Quotient of num*2^F by den is below 2^QB unless ovf is set.
  always_comb begin
    nsh = CW'(num_i) << FRAC_BITS;
    dsh = CW'(den_i) << QB;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] tr;
    always_comb begin
      tr       = {rem_q[k][RW-2:0], lo_q[k][QB-1]};
      ge[k]    = tr >= {1'b0, den_q[k]};
      rem_d[k] = ge[k] ? (tr - {1'b0, den_q[k]}) : tr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(nsh >> QB);
      lo_q[0]  <= nsh[QB-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= nsh >= dsh;
      for (int k = 0; k < QB; k++) begin
        rem_q[k+1] <= rem_d[k];
        lo_q[k+1]  <= lo_q[k] << 1;
        quo_q[k+1] <= {quo_q[k][QB-2:0], ge[k]};
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign quo_o = quo_q[QB];
  assign rem_o = rem_q[QB];
  assign den_o = den_q[QB];
  assign ovf_o = ovf_q[QB];

endmodule

// File: hdl/vertex_transform_perspective_divide_unit.sv
// Vertex transform with perspective divide.
// Input channel (in_valid_i / in_stall_o): a load item (req_type 0) writes
// one matrix entry, row*4+column; a transform item (req_type 1) sends a
// point (x, y, z) with w = 1 through the matrix as a row vector.
// Output channel (out_valid_o / out_stall_i): one item per transform with
// x, y, z divided by w (or undivided and w_was_zero set when w is zero),
// rounded and clamped to Q16.16, saturated set on any clamp.
// Loads give no output item and take effect for transforms accepted later.
// Throughput: one item per cycle while the output is not stalled. From
// acceptance to out_valid_o an item passes multiply, column sum, magnitude,
// overflow check, one quotient bit per stage for 33 stages, and the rounding/output register.
// The divide pipeline sets the depth.
// Reset loads the identity matrix and empties the pipeline.
// A stalled output holds its item; the whole pipeline then stops and
// in_stall_o is raised, so nothing is dropped or repeated.
module vertex_transform_perspective_divide_unit #(
  parameter int unsigned FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [3:0]  entry_index_i,
  input  logic [31:0] entry_value_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        w_was_zero_o,
  output logic        saturated_o
);

  localparam int unsigned DW  = vtpd_pkg::DW;
  localparam int unsigned SW  = vtpd_pkg::SW;
  localparam int unsigned MW  = vtpd_pkg::MW;
  localparam int unsigned QB  = vtpd_pkg::QB;
  localparam int unsigned DIM = vtpd_pkg::DIM;
  localparam int unsigned NE  = vtpd_pkg::NENT;
  localparam logic [DW-1:0] ONE  = DW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic adv, acc;
  logic [DW-1:0] pt [3];

  logic [DW-1:0] mat_q [NE];

  logic                v1_q;
  logic signed [63:0]  prod_q [3][DIM];
  logic [DW-1:0]       r3_q   [DIM];

  logic                v2_q;
  logic signed [SW-1:0] sum_q [DIM];

  logic                v3_q;
  logic                mneg_q [DIM];
  logic [MW-1:0]       mmag_q [DIM];

  vtpd_pkg::side_t side_d;
  vtpd_pkg::side_t side_q [QB+1];
  vtpd_pkg::side_t fin;

  logic [QB-1:0] quo [3];
  logic [MW:0]   rem [3];
  logic [MW-1:0] den [3];
  logic          ovf [3];

  logic          out_valid_q;
  logic [DW-1:0] out_q [3];
  logic          wz_q, sat_q;
  logic [DW-1:0] res_val [3];
  logic          res_sat;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;
  assign pt[0]      = point_x_i;
  assign pt[1]      = point_y_i;
  assign pt[2]      = point_z_i;

  // Matrix: the products for a transform are taken at acceptance, so a load
  // right behind it cannot disturb it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NE; k++) mat_q[k] <= (k % 5 == 0) ? ONE : '0;
    end else if (acc && (req_type_i == vtpd_pkg::REQ_LOAD)) begin
      mat_q[entry_index_i] <= entry_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k <= QB; k++) side_q[k] <= '0;
    end else if (adv) begin
      v1_q        <= acc && (req_type_i == vtpd_pkg::REQ_XFORM);
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      side_q[0]   <= side_d;
      for (int k = 0; k < QB; k++) side_q[k+1] <= side_q[k];
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < DIM; c++) begin
          prod_q[r][c] <= $signed(pt[r]) * $signed(mat_q[r*DIM+c]);
        end
      end
      for (int c = 0; c < DIM; c++) begin
        r3_q[c] <= mat_q[3*DIM+c];
        sum_q[c] <= SW'(prod_q[0][c]) + SW'(prod_q[1][c]) + SW'(prod_q[2][c])
                  + (SW'($signed(r3_q[c])) <<< FRAC_BITS);
        mneg_q[c] <= sum_q[c][SW-1];
        mmag_q[c] <= sum_q[c][SW-1] ? MW'(-sum_q[c]) : MW'(sum_q[c]);
      end
      for (int c = 0; c < 3; c++) out_q[c] <= res_val[c];
      wz_q  <= fin.wz;
      sat_q <= res_sat;
    end
  end

  // Undivided path: round off the fraction and clamp now, carry the result.
  always_comb begin
    logic [SW-1:0] um;
    logic [DW:0]   r;
    side_d       = '0;
    side_d.valid = v3_q;
    side_d.wz    = (mmag_q[3] == '0);
    for (int c = 0; c < 3; c++) begin
      side_d.dneg[c] = mneg_q[c] ^ mneg_q[3];
      um = ({1'b0, mmag_q[c]} + HALF) >> FRAC_BITS;
      r  = vtpd_pkg::sat32(mneg_q[c], um, 1'b0);
      side_d.uval[c] = r[DW-1:0];
      side_d.usat    = side_d.usat | r[DW];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    vtpd_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mmag_q[c]),
      .den_i (mmag_q[3]),
      .quo_o (quo[c]),
      .rem_o (rem[c]),
      .den_o (den[c]),
      .ovf_o (ovf[c])
    );
  end

  assign fin = side_q[QB];

  // Round to nearest, ties away from zero: bump when 2*rem >= den.
  always_comb begin
    logic          rnd;
    logic [SW-1:0] m;
    logic [DW:0]   r;
    res_sat = fin.wz ? fin.usat : 1'b0;
    for (int c = 0; c < 3; c++) begin
      rnd = {rem[c], 1'b0} >= {2'b00, den[c]};
      m   = SW'(quo[c]) + SW'(rnd);
      r   = vtpd_pkg::sat32(fin.dneg[c], m, ovf[c]);
      if (fin.wz) begin
        res_val[c] = fin.uval[c];
      end else begin
        res_val[c] = r[DW-1:0];
        res_sat    = res_sat | r[DW];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign w_was_zero_o = wz_q;
  assign saturated_o  = sat_q;

endmodule

// File: hdl/vtpd_checker.sv
module vtpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o,
  input logic        saturated_o
);

  // The input side only waits on a held output item.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held output item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_x_o)
                                      && $stable(out_y_o) && $stable(out_z_o)))
    else $error("stalled output item changed");

  // A clamp always shows up as an extreme value in some coordinate.
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (out_x_o == 32'h7FFF_FFFF || out_x_o == 32'h8000_0000 ||
       out_y_o == 32'h7FFF_FFFF || out_y_o == 32'h8000_0000 ||
       out_z_o == 32'h7FFF_FFFF || out_z_o == 32'h8000_0000))
    else $error("saturated flag without a clamped coordinate");

endmodule

bind vertex_transform_perspective_divide_unit vtpd_checker u_chk (.*);
